// ===== src/fpda_pkg.sv =====
package fpda_pkg;

   localparam int DEF_INT_BITS        = 16;
   localparam int DEF_FRAC_BITS       = 16;
   localparam int DEF_MAX_INT_DIGITS  = 10;
   localparam int DEF_MAX_FRAC_DIGITS = 8;
   localparam int QUEUE_DEPTH         = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0]  CSR_INT_DIGITS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_FRAC_DIGITS = 2'd1;
   localparam logic [CSR_DATA_W-1:0] RST_INT_DIGITS  = 4'd3;
   localparam logic [CSR_DATA_W-1:0] RST_FRAC_DIGITS = 4'd1;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CONV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_INT,
      B_DOT,
      B_FRAC
   } back_state_type;

   // queue handshake between two modules
   typedef struct packed {
      logic push_valid;
      logic push_ready;
   } queue_hs_type;

endpackage

// ===== src/fpda_queue.sv =====
module fpda_queue
   import fpda_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

endmodule

// ===== src/fpda_front.sv =====
module fpda_front
   import fpda_pkg::*;
#(
   parameter int INT_BITS        = DEF_INT_BITS,
   parameter int FRAC_BITS       = DEF_FRAC_BITS,
   parameter int MAX_INT_DIGITS  = DEF_MAX_INT_DIGITS,
   parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
   parameter int JOB_W           = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_value,
   input  logic [CSR_DATA_W-1:0] int_digits,
   input  logic [CSR_DATA_W-1:0] frac_digits,
   output queue_hs_type          hs_out,
   input  logic                  hs_ready,
   output logic [JOB_W-1:0]      job_data
);

   localparam int FW   = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int NG_W = $clog2(MAX_INT_DIGITS + 1);
   localparam int NF_W = (MAX_FRAC_DIGITS > 0) ? $clog2(MAX_FRAC_DIGITS + 1) : 1;

   front_state_type  state_ff, state_in;
   logic [INT_BITS-1:0] ipart_ff, ipart_in;
   logic [FW-1:0]       frac_ff;
   logic [NG_W-1:0]     ng_ff, cnt_ff, cnt_in;
   logic [NF_W-1:0]     nf_ff;
   logic [3:0]          digs_ff [MAX_INT_DIGITS];
   logic [3:0]          digs_in [MAX_INT_DIGITS];

   logic                accept;
   logic                step;
   logic [63:0]         value_ext;
   logic [INT_BITS-1:0] ipart_new;
   logic [FW-1:0]       frac_new;
   logic [NG_W-1:0]     ng_new;
   logic [NF_W-1:0]     nf_new;
   logic [31:0]         x32, q32;
   logic [63:0]         prod;
   logic [3:0]          ten_q, rem;
   logic [4*MAX_INT_DIGITS-1:0] digs_flat;

   assign accept    = req_valid && req_ready;
   assign value_ext = {32'd0, req_value} >> FRAC_BITS;
   assign ipart_new = value_ext[INT_BITS-1:0];
   assign frac_new  = (FRAC_BITS == 0) ? '0 : req_value[FW-1:0];
   assign ng_new    = ({28'd0, int_digits} > 32'(MAX_INT_DIGITS)) ?
                      NG_W'(MAX_INT_DIGITS) : NG_W'(int_digits);
   assign nf_new    = ({28'd0, frac_digits} > 32'(MAX_FRAC_DIGITS)) ?
                      NF_W'(MAX_FRAC_DIGITS) : NF_W'(frac_digits);

   // divide by ten through the reciprocal; the remainder needs only 4 bits
   assign x32   = 32'(ipart_ff);
   assign prod  = 64'(x32) * 64'(RECIP_TEN);
   assign q32   = 32'(prod >> RECIP_SHIFT);
   assign ten_q = {q32[0], 3'b000} + {q32[2:0], 1'b0};
   assign rem   = x32[3:0] - ten_q;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = (ng_new == '0) ? F_PUSH : F_CONV;
            end
         end
         F_CONV: begin
            if (cnt_ff == NG_W'(1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (hs_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready         = 1'b0;
      hs_out.push_valid = 1'b0;
      hs_out.push_ready = hs_ready;
      step              = 1'b0;
      unique case (state_ff)
         F_IDLE:  req_ready         = 1'b1;
         F_CONV:  step              = 1'b1;
         F_PUSH:  hs_out.push_valid = 1'b1;
         default: req_ready         = 1'b0;
      endcase
   end

   always_comb begin
      ipart_in = ipart_ff;
      cnt_in   = cnt_ff;
      digs_in  = digs_ff;
      if (accept) begin
         ipart_in = ipart_new;
         cnt_in   = ng_new;
      end else if (step) begin
         // push the new digit in at the bottom: the most significant ends there
         ipart_in   = q32[INT_BITS-1:0];
         cnt_in     = cnt_ff - 1'b1;
         digs_in[0] = rem;
         for (int i = 1; i < MAX_INT_DIGITS; i++) begin
            digs_in[i] = digs_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ipart_ff <= ipart_in;
      cnt_ff   <= cnt_in;
      digs_ff  <= digs_in;
      if (accept) begin
         frac_ff <= frac_new;
         ng_ff   <= ng_new;
         nf_ff   <= nf_new;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_INT_DIGITS; i++) begin
         digs_flat[i*4 +: 4] = digs_ff[i];
      end
   end

   assign job_data = {digs_flat, frac_ff, ng_ff, nf_ff};

   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_CONV) |-> (cnt_ff != '0))
      else $error("conversion running with no digits left");

endmodule

// ===== src/fpda_back.sv =====
module fpda_back
   import fpda_pkg::*;
#(
   parameter int FRAC_BITS       = DEF_FRAC_BITS,
   parameter int MAX_INT_DIGITS  = DEF_MAX_INT_DIGITS,
   parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
   parameter int JOB_W           = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  logic [JOB_W-1:0] job_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_char_code,
   output logic             rsp_last
);

   localparam int FW   = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int PW   = FW + 4;
   localparam int NG_W = $clog2(MAX_INT_DIGITS + 1);
   localparam int NF_W = (MAX_FRAC_DIGITS > 0) ? $clog2(MAX_FRAC_DIGITS + 1) : 1;

   back_state_type  state_ff, state_in;
   logic [3:0]      digs_ff [MAX_INT_DIGITS];
   logic [3:0]      digs_in [MAX_INT_DIGITS];
   logic [FW-1:0]   frem_ff, frem_in;
   logic [NG_W-1:0] icnt_ff, icnt_in;
   logic [NF_W-1:0] fcnt_ff, fcnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      char_ff, char_in;
   logic            last_ff, last_in;

   logic [4*MAX_INT_DIGITS-1:0] job_digs;
   logic [FW-1:0]   job_frac;
   logic [NG_W-1:0] job_ng;
   logic [NF_W-1:0] job_nf;
   logic            out_free;
   logic            emit;
   logic [PW-1:0]   prod10;
   logic [3:0]      fdigit;

   assign {job_digs, job_frac, job_ng, job_nf} = job_data;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign prod10 = (PW'(frem_ff) << 3) + (PW'(frem_ff) << 1);
   assign fdigit = prod10[FRAC_BITS +: 4];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               state_in = (job_ng == '0) ? B_DOT : B_INT;
            end
         end
         B_INT: begin
            if (out_free && icnt_ff == NG_W'(1)) begin
               state_in = B_DOT;
            end
         end
         B_DOT: begin
            if (out_free) begin
               state_in = (fcnt_ff == '0) ? B_IDLE : B_FRAC;
            end
         end
         B_FRAC: begin
            if (out_free && fcnt_ff == NF_W'(1)) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      emit      = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      digs_in   = digs_ff;
      frem_in   = frem_ff;
      icnt_in   = icnt_ff;
      fcnt_in   = fcnt_ff;
      unique case (state_ff)
         B_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               for (int i = 0; i < MAX_INT_DIGITS; i++) begin
                  digs_in[i] = job_digs[i*4 +: 4];
               end
               frem_in = job_frac;
               icnt_in = job_ng;
               fcnt_in = job_nf;
            end
         end
         B_INT: begin
            if (out_free) begin
               emit    = 1'b1;
               char_in = CHAR_ZERO + {4'd0, digs_ff[0]};
               last_in = 1'b0;
               icnt_in = icnt_ff - 1'b1;
               // advance the next lower digit to the head
               for (int i = 0; i < MAX_INT_DIGITS - 1; i++) begin
                  digs_in[i] = digs_ff[i+1];
               end
            end
         end
         B_DOT: begin
            if (out_free) begin
               emit    = 1'b1;
               char_in = CHAR_DOT;
               last_in = (fcnt_ff == '0);
            end
         end
         B_FRAC: begin
            if (out_free) begin
               emit    = 1'b1;
               char_in = CHAR_ZERO + {4'd0, fdigit};
               last_in = (fcnt_ff == NF_W'(1));
               frem_in = prod10[FW-1:0];
               fcnt_in = fcnt_ff - 1'b1;
            end
         end
         default: job_ready = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digs_ff <= digs_in;
      frem_ff <= frem_in;
      icnt_ff <= icnt_in;
      fcnt_ff <= fcnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

   a_int_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_INT) |-> (icnt_ff != '0))
      else $error("integer digit emitted with count at zero");

   a_frac_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FRAC) |-> (fcnt_ff != '0))
      else $error("fraction digit emitted with count at zero");

   // an idle sequencer may load the next job under a stalled word
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && state_ff != B_IDLE) |=>
      (state_ff == $past(state_ff)))
      else $error("sequencer advanced while the output was stalled");

endmodule

// ===== src/fixed_point_to_decimal_ascii_unit.sv =====
// Fixed-point to decimal ASCII converter.
// req channel: one unsigned fixed-point word per value (INT_BITS integer
// bits above FRAC_BITS fraction bits). rsp channel: one ASCII character per
// word, int_digits integer digits (leading zeros kept, excess high digits
// dropped), then '.', then frac_digits truncated fraction digits; rsp_last
// marks the final character. Both counts saturate at their maximums.
// csr port: write int_digits at index 0 and frac_digits at index 1 while idle.
// The front splits the integer part into digits, one divide-by-ten step per
// cycle, and hands the job through a two-entry queue to the back, which
// sends one character per cycle while the receiver is ready. The front
// can accept the next value while the back still sends the characters of
// earlier ones; the back, with its one-character output register, limits
// the throughput.
// Reset clears both state machines, the queue and the output valid, and sets
// int_digits to 3 and frac_digits to 1. When the receiver stalls, the output
// word holds, the back waits, the queue fills, and then req_ready drops.
module fixed_point_to_decimal_ascii_unit
   import fpda_pkg::*;
#(
   parameter int INT_BITS        = DEF_INT_BITS,
   parameter int FRAC_BITS       = DEF_FRAC_BITS,
   parameter int MAX_INT_DIGITS  = DEF_MAX_INT_DIGITS,
   parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int FW    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int NG_W  = $clog2(MAX_INT_DIGITS + 1);
   localparam int NF_W  = (MAX_FRAC_DIGITS > 0) ? $clog2(MAX_FRAC_DIGITS + 1) : 1;
   localparam int JOB_W = 4 * MAX_INT_DIGITS + FW + NG_W + NF_W;

   logic [CSR_DATA_W-1:0] int_digits_ff, int_digits_in;
   logic [CSR_DATA_W-1:0] frac_digits_ff, frac_digits_in;

   queue_hs_type     front_hs;
   logic             queue_ready;
   logic [JOB_W-1:0] push_data;
   logic             pop_valid, pop_ready;
   logic [JOB_W-1:0] pop_data;

   always_comb begin
      int_digits_in  = int_digits_ff;
      frac_digits_in = frac_digits_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INT_DIGITS:  int_digits_in  = csr_write_data;
            CSR_FRAC_DIGITS: frac_digits_in = csr_write_data;
            default:         int_digits_in  = int_digits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_digits_ff  <= RST_INT_DIGITS;
         frac_digits_ff <= RST_FRAC_DIGITS;
      end else begin
         int_digits_ff  <= int_digits_in;
         frac_digits_ff <= frac_digits_in;
      end
   end

   fpda_front #(
      .INT_BITS        (INT_BITS),
      .FRAC_BITS       (FRAC_BITS),
      .MAX_INT_DIGITS  (MAX_INT_DIGITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
      .JOB_W           (JOB_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .int_digits  (int_digits_ff),
      .frac_digits (frac_digits_ff),
      .hs_out      (front_hs),
      .hs_ready    (queue_ready),
      .job_data    (push_data)
   );

   fpda_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_hs.push_valid),
      .push_ready (queue_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fpda_back #(
      .FRAC_BITS       (FRAC_BITS),
      .MAX_INT_DIGITS  (MAX_INT_DIGITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
      .JOB_W           (JOB_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (pop_valid),
      .job_ready     (pop_ready),
      .job_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   a_push_seen: assert property (@(posedge clock) disable iff (reset)
      (front_hs.push_valid && !front_hs.push_ready) |=> front_hs.push_valid)
      else $error("front dropped a job the queue had not taken");

endmodule
